@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the queue engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DQE_ASSERT_CLKD(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DQE_ASSERT(label, prop, msg) \
  `DQE_ASSERT_CLKD(label, clk_i, rst_ni, prop, msg)
`else
`define DQE_ASSERT_CLKD(label, clk, rstn, prop, msg)
`define DQE_ASSERT(label, prop, msg)
`endif
`endif

@@ rtl/core/dqe_pkg.sv @@
// Types and constants of the double-ended queue engine.
package dqe_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int REQ_W          = 4;
  localparam int STATUS_W       = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_HEAD  = 4'd0,
    REQ_PUSH_TAIL  = 4'd1,
    REQ_POP_HEAD   = 4'd2,
    REQ_POP_TAIL   = 4'd3,
    REQ_PEEK_FRONT = 4'd4,
    REQ_PEEK_REAR  = 4'd5,
    REQ_READ_AT    = 4'd6,
    REQ_SEARCH     = 4'd7,
    REQ_INSERT_AT  = 4'd8,
    REQ_REMOVE_AT  = 4'd9,
    REQ_CLEAR      = 4'd10
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_OPEN  = 2'd1,
    SH_CLOSE = 2'd2
  } shift_e;

  typedef struct packed {
    logic   wr_en;
    shift_e shift;
  } cell_cmd_t;

endpackage

@@ rtl/core/double_ended_queue_engine.sv @@
// Top level of the double-ended queue engine: request control and the cell chain.
//
//  channel   direction  handshake                    payload
//  request   in         start high, busy low         req_type_i, value_i, position_i
//  result    out        done_o, one cycle            data_out_o, found_position_o,
//                                                    status_o, occupancy_o
//
// Each request is first registered, then executed in the S_EXEC state, in which every cell
// compares, shifts or loads in parallel while the control decodes the request.
// The result appears on the cycle after that, marked by done_o, and a new request
// may be accepted in that same cycle; no new request is accepted while one executes.
// Reset empties the queue at once; the cell contents are not cleared.
// The receiver cannot stall; busy is high only during the execute cycle.
`include "assert_macros.svh"

module double_ended_queue_engine #(
  parameter int DEPTH      = dqe_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqe_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [dqe_pkg::REQ_W-1:0]    req_type_i,
  input  logic [DATA_WIDTH-1:0]        value_i,
  input  logic [CNT_W-1:0]             position_i,
  output logic                         done_o,
  output logic [DATA_WIDTH-1:0]        data_out_o,
  output logic [IDX_W-1:0]             found_position_o,
  output logic [dqe_pkg::STATUS_W-1:0] status_o,
  output logic [CNT_W-1:0]             occupancy_o
);

  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);

  dqe_pkg::state_e state_q, state_d;

  logic [dqe_pkg::REQ_W-1:0] req_q;
  logic [DATA_WIDTH-1:0]     value_q;
  logic [CNT_W-1:0]          pos_q;
  logic [CNT_W-1:0]          count_q, count_d;

  logic                      done_q;
  logic [DATA_WIDTH-1:0]     data_q, data_d;
  logic [IDX_W-1:0]          found_q, found_d;
  dqe_pkg::status_e          status_q, status_d;

  logic                      exec;
  logic                      accept;
  logic                      full_w, empty_w;
  logic [IDX_W-1:0]          rd_idx;
  logic [IDX_W-1:0]          at_idx;
  logic [DATA_WIDTH-1:0]     rd_data;
  dqe_pkg::cell_cmd_t        cmd;
  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;

  logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
  logic [DEPTH-1:0]          cell_match;

  // Request state machine.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dqe_pkg::S_IDLE: begin
        if (start) begin
          state_d = dqe_pkg::S_EXEC;
        end
      end
      dqe_pkg::S_EXEC: state_d = dqe_pkg::S_IDLE;
      default:         state_d = dqe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_q)
      dqe_pkg::S_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      dqe_pkg::S_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqe_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    if (exec) begin
      data_q   <= data_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  assign full_w  = (count_q == Full);
  assign empty_w = (count_q == '0);

  always_comb begin
    case (req_q)
      dqe_pkg::REQ_POP_HEAD, dqe_pkg::REQ_PEEK_FRONT: rd_idx = '0;
      dqe_pkg::REQ_POP_TAIL, dqe_pkg::REQ_PEEK_REAR:  rd_idx = IDX_W'(count_q - 1'b1);
      default:                                        rd_idx = IDX_W'(pos_q);
    endcase
  end

  assign rd_data = cell_data[rd_idx];

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i] && (CNT_W'(i) < count_q)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Request decoder.
  always_comb begin
    cmd.wr_en = 1'b0;
    cmd.shift = dqe_pkg::SH_NONE;
    at_idx    = IDX_W'(pos_q);
    count_d   = count_q;
    data_d    = '0;
    found_d   = '0;
    status_d  = dqe_pkg::STAT_OK;
    if (exec) begin
      unique case (req_q) inside
        dqe_pkg::REQ_PUSH_HEAD: begin
          if (full_w) begin
            status_d = dqe_pkg::STAT_FULL;
          end else begin
            cmd.wr_en = 1'b1;
            cmd.shift = dqe_pkg::SH_OPEN;
            at_idx    = '0;
            count_d   = count_q + 1'b1;
          end
        end
        dqe_pkg::REQ_PUSH_TAIL: begin
          if (full_w) begin
            status_d = dqe_pkg::STAT_FULL;
          end else begin
            cmd.wr_en = 1'b1;
            at_idx    = IDX_W'(count_q);
            count_d   = count_q + 1'b1;
          end
        end
        dqe_pkg::REQ_POP_HEAD, dqe_pkg::REQ_POP_TAIL,
        dqe_pkg::REQ_PEEK_FRONT, dqe_pkg::REQ_PEEK_REAR: begin
          if (empty_w) begin
            status_d = dqe_pkg::STAT_EMPTY;
          end else begin
            data_d = rd_data;
            if (req_q == dqe_pkg::REQ_POP_HEAD) begin
              cmd.shift = dqe_pkg::SH_CLOSE;
              at_idx    = '0;
            end
            if ((req_q == dqe_pkg::REQ_POP_HEAD) || (req_q == dqe_pkg::REQ_POP_TAIL)) begin
              count_d = count_q - 1'b1;
            end
          end
        end
        dqe_pkg::REQ_READ_AT, dqe_pkg::REQ_REMOVE_AT: begin
          if (pos_q >= count_q) begin
            status_d = dqe_pkg::STAT_BADPOS;
          end else begin
            data_d = rd_data;
            if (req_q == dqe_pkg::REQ_REMOVE_AT) begin
              cmd.shift = dqe_pkg::SH_CLOSE;
              count_d   = count_q - 1'b1;
            end
          end
        end
        dqe_pkg::REQ_SEARCH: begin
          if (hit) begin
            found_d = hit_idx;
          end else begin
            status_d = dqe_pkg::STAT_NOTFOUND;
          end
        end
        dqe_pkg::REQ_INSERT_AT: begin
          if (full_w) begin
            status_d = dqe_pkg::STAT_FULL;
          end else if (pos_q > count_q) begin
            status_d = dqe_pkg::STAT_BADPOS;
          end else begin
            cmd.wr_en = 1'b1;
            cmd.shift = dqe_pkg::SH_OPEN;
            count_d   = count_q + 1'b1;
          end
        end
        dqe_pkg::REQ_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = cell_data[g];
    end else begin : g_inner_l
      assign left_data = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_data = cell_data[g];
    end else begin : g_inner_r
      assign right_data = cell_data[g+1];
    end

    dqe_cell #(
      .IDX        (g),
      .IDX_W      (IDX_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .at_idx_i     (at_idx),
      .wr_data_i    (value_q),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .key_i        (value_q),
      .data_o       (cell_data[g]),
      .match_o      (cell_match[g])
    );
  end

  assign done_o           = done_q;
  assign data_out_o       = data_q;
  assign found_position_o = found_q;
  assign status_o         = status_q;
  assign occupancy_o      = count_q;

  `DQE_ASSERT(a_done_after_exec, exec |=> done_o, "Result strobe missing after execute cycle.")
  `DQE_ASSERT(a_done_not_busy, done_o |-> !busy, "Result strobe raised while busy.")
  `DQE_ASSERT(a_accept_busy, accept |=> (busy && !done_o), "Accepted transaction did not execute.")
  `DQE_ASSERT(a_count_bound, count_q <= Full, "Occupancy exceeds queue depth.")
  `DQE_ASSERT(a_full_push_holds,
    (exec && full_w && ((req_q == dqe_pkg::REQ_PUSH_HEAD) || (req_q == dqe_pkg::REQ_PUSH_TAIL)))
    |=> ($stable(count_q) && (status_o == dqe_pkg::STAT_FULL)),
    "Push on a full queue changed occupancy.")

endmodule

@@ rtl/core/dqe_cell.sv @@
// One storage cell of the queue chain, holding the entry at a fixed position.
module dqe_cell #(
  parameter int IDX        = 0,
  parameter int IDX_W      = 4,
  parameter int DATA_WIDTH = dqe_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  dqe_pkg::cell_cmd_t    cmd_i,
  input  logic [IDX_W-1:0]      at_idx_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.shift)
      dqe_pkg::SH_OPEN: begin
        if (MyIdx > at_idx_i) begin
          data_d = left_data_i;
        end
      end
      dqe_pkg::SH_CLOSE: begin
        if (MyIdx >= at_idx_i) begin
          data_d = right_data_i;
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.wr_en && (MyIdx == at_idx_i)) begin
      data_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule
